// File: src/assert_macros.svh
// Assertion shorthands; each expects clk_i and rst_ni in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off during reset.
`define ASSERT_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, off during reset.
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// File: src/ttg_pkg.sv
`default_nettype none

package ttg_pkg;

  localparam int CoordW    = 16;
  localparam int DeltaW    = CoordW + 1;
  localparam int ProdW     = 2 * DeltaW;
  localparam int AccW      = ProdW + 1;
  localparam int QuotW     = 32;
  localparam int FracShift = 20;
  localparam int LowNumBits = QuotW - FracShift;
  localparam int AxisNum   = 3;
  localparam int AccNum    = AxisNum + 1;
  localparam int AccSelW   = 2;
  localparam int MulSteps  = 8;
  localparam int MStepW    = 4;
  localparam int OutIdxW   = 16;

  typedef logic signed [CoordW-1:0] coord_t;
  typedef logic signed [DeltaW-1:0] delta_t;
  typedef logic signed [AccW-1:0]   acc_t;
  typedef logic [AccW-1:0]          mag_t;
  typedef logic [QuotW-1:0]         quot_t;

  // Accumulator slots of the multiply-accumulate unit
  localparam logic [AccSelW-1:0] AccDet  = 2'd0;
  localparam logic [AccSelW-1:0] AccNumX = 2'd1;
  localparam logic [AccSelW-1:0] AccNumY = 2'd2;
  localparam logic [AccSelW-1:0] AccNumZ = 2'd3;

  localparam quot_t TanMax = 32'h7FFF_FFFF;
  localparam quot_t TanMin = 32'h8000_0000;

  typedef struct packed {
    logic               en;
    logic               sub;
    logic [AccSelW-1:0] sel;
  } mac_ctl_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_PREP,
    ST_DIV,
    ST_FIN,
    ST_EMIT
  } state_e;

endpackage

`default_nettype wire

// File: src/ttg_mac.sv
`default_nettype none

module ttg_mac import ttg_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  mac_ctl_t ctl_i,
  input  delta_t   a_i,
  input  delta_t   b_i,
  output acc_t     acc_o [AccNum]
);

  logic signed [ProdW-1:0] prod_q;
  mac_ctl_t                ctl_q;
  acc_t                    acc_q [AccNum];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else begin
      ctl_q <= ctl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= a_i * b_i;
  end

  // First product of a pair loads the slot, the second is subtracted
  always_ff @(posedge clk_i) begin
    if (ctl_q.en) begin
      if (ctl_q.sub) begin
        acc_q[ctl_q.sel] <= acc_q[ctl_q.sel] - AccW'(prod_q);
      end else begin
        acc_q[ctl_q.sel] <= AccW'(prod_q);
      end
    end
  end

  assign acc_o = acc_q;

endmodule

`default_nettype wire

// File: src/ttg_div.sv
`default_nettype none

module ttg_div import ttg_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  start_i,
  input  mag_t  dm_i,
  input  mag_t  nm_i [AxisNum],
  output quot_t q_o [AxisNum],
  output logic  ovf_o [AxisNum],
  output logic  done_o
);

  localparam int CntW = $clog2(QuotW);

  logic            busy_q;
  logic [CntW-1:0] cnt_q;
  mag_t            dm_q;
  mag_t            r_q [AxisNum];
  quot_t           x_q [AxisNum];
  logic            ovf_q [AxisNum];
  logic [AccW+1:0] diff [AxisNum];

  always_comb begin
    for (int k = 0; k < AxisNum; k++) begin
      diff[k] = {1'b0, r_q[k], x_q[k][QuotW-1]} - {2'b00, dm_q};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 1'b1;
      if (cnt_q == CntW'(QuotW - 1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  // Dividend is the numerator magnitude shifted up by the fraction bits;
  // its upper part seeds the remainder, the lower part shifts in bit by bit
  // while quotient bits shift in at the bottom.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dm_q <= dm_i;
      for (int k = 0; k < AxisNum; k++) begin
        r_q[k]   <= nm_i[k] >> LowNumBits;
        x_q[k]   <= {nm_i[k][LowNumBits-1:0], {FracShift{1'b0}}};
        ovf_q[k] <= (nm_i[k] >> LowNumBits) >= dm_i;
      end
    end else if (busy_q) begin
      for (int k = 0; k < AxisNum; k++) begin
        if (!diff[k][AccW+1]) begin
          r_q[k] <= diff[k][AccW-1:0];
          x_q[k] <= {x_q[k][QuotW-2:0], 1'b1};
        end else begin
          r_q[k] <= {r_q[k][AccW-2:0], x_q[k][QuotW-1]};
          x_q[k] <= {x_q[k][QuotW-2:0], 1'b0};
        end
      end
    end
  end

  assign q_o    = x_q;
  assign ovf_o  = ovf_q;
  assign done_o = busy_q && (cnt_q == CntW'(QuotW - 1));

endmodule

`default_nettype wire

// File: src/triangle_tangent_generator_top.sv
// Channel  Handshake                  Payload
// in       in_valid_i / in_ready_o    vertex_index_i, pos_{x,y,z}_i, tex_{u,v}_i
// out      out_valid_o / out_ready_i  out_vertex_index_o, tangent_{x,y,z}_o,
//                                     degenerate_o, last_o
// First and second corner of a triangle: held as they are accepted.
// Third corner: products on the shared 17x17 multiplier, a setup state, the radix-2
// divider (one quotient bit per cycle), a saturate state, then three results at one per
// cycle while out_ready_i is high.
// in_ready_o stays low from the third corner until its last result is taken.
// Reset clears the sequencer and the corner count; held corners are not cleared.
`default_nettype none

module triangle_tangent_generator_top import ttg_pkg::*; #(
  parameter int INDEX_BITS = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [OutIdxW-1:0]   vertex_index_i,
  input  coord_t               pos_x_i,
  input  coord_t               pos_y_i,
  input  coord_t               pos_z_i,
  input  coord_t               tex_u_i,
  input  coord_t               tex_v_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [OutIdxW-1:0]   out_vertex_index_o,
  output logic signed [QuotW-1:0] tangent_x_o,
  output logic signed [QuotW-1:0] tangent_y_o,
  output logic signed [QuotW-1:0] tangent_z_o,
  output logic                 degenerate_o,
  output logic                 last_o
);

  localparam int HeldW = (INDEX_BITS < OutIdxW) ? INDEX_BITS : OutIdxW;

  function automatic delta_t sub_ext(input coord_t a, input coord_t b);
    sub_ext = {a[CoordW-1], a} - {b[CoordW-1], b};
  endfunction

  state_e state_q, state_d;
  logic [1:0]        ccnt_q;
  logic [1:0]        ecnt_q;
  logic [MStepW-1:0] mstep_q;

  logic [HeldW-1:0] held_idx_q [3];
  coord_t           held_pos_q [2][AxisNum];
  coord_t           held_tex_q [2][2];

  delta_t e1_q [AxisNum];
  delta_t e2_q [AxisNum];
  delta_t du1_q, dv1_q, du2_q, dv2_q;

  logic  sign_q [AxisNum];
  logic  degen_q;
  quot_t tan_q [AxisNum];
  quot_t tan_d [AxisNum];

  coord_t   pos_in [AxisNum];
  logic     in_acc, out_acc;
  mac_ctl_t mac_ctl;
  delta_t   mul_a, mul_b;
  acc_t     acc [AccNum];
  logic     div_start, div_done;
  mag_t     dm;
  mag_t     nm [AxisNum];
  quot_t    quot [AxisNum];
  logic     ovf [AxisNum];

  assign pos_in[0] = pos_x_i;
  assign pos_in[1] = pos_y_i;
  assign pos_in[2] = pos_z_i;

  assign in_acc  = in_valid_i && in_ready_o;
  assign out_acc = out_valid_o && out_ready_i;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (in_acc && ccnt_q == 2'd2) state_d = ST_MUL;
      ST_MUL:  if (mstep_q == MStepW'(MulSteps)) state_d = ST_PREP;
      ST_PREP: state_d = ST_DIV;
      ST_DIV:  if (div_done) state_d = ST_FIN;
      ST_FIN:  state_d = ST_EMIT;
      ST_EMIT: if (out_acc && ecnt_q == 2'd2) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // Outputs of the sequencer
  always_comb begin
    in_ready_o  = (state_q == ST_IDLE);
    out_valid_o = (state_q == ST_EMIT);
    div_start   = (state_q == ST_PREP);
  end

  // Product schedule: det = du1*dv2 - du2*dv1, n = dv2*e1 - dv1*e2
  always_comb begin
    mac_ctl.en  = (state_q == ST_MUL) && (mstep_q != MStepW'(MulSteps));
    mac_ctl.sub = mstep_q[0];
    unique case (mstep_q[2:0])
      3'd0: begin mul_a = du1_q; mul_b = dv2_q;    mac_ctl.sel = AccDet;  end
      3'd1: begin mul_a = du2_q; mul_b = dv1_q;    mac_ctl.sel = AccDet;  end
      3'd2: begin mul_a = dv2_q; mul_b = e1_q[0];  mac_ctl.sel = AccNumX; end
      3'd3: begin mul_a = dv1_q; mul_b = e2_q[0];  mac_ctl.sel = AccNumX; end
      3'd4: begin mul_a = dv2_q; mul_b = e1_q[1];  mac_ctl.sel = AccNumY; end
      3'd5: begin mul_a = dv1_q; mul_b = e2_q[1];  mac_ctl.sel = AccNumY; end
      3'd6: begin mul_a = dv2_q; mul_b = e1_q[2];  mac_ctl.sel = AccNumZ; end
      3'd7: begin mul_a = dv1_q; mul_b = e2_q[2];  mac_ctl.sel = AccNumZ; end
      default: begin mul_a = '0; mul_b = '0;       mac_ctl.sel = AccDet;  end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      ccnt_q  <= '0;
      ecnt_q  <= '0;
      mstep_q <= '0;
    end else begin
      state_q <= state_d;
      if (in_acc) begin
        ccnt_q <= (ccnt_q == 2'd2) ? 2'd0 : ccnt_q + 2'd1;
      end
      mstep_q <= (state_q == ST_MUL) ? mstep_q + 1'b1 : '0;
      if (out_acc) begin
        ecnt_q <= (ecnt_q == 2'd2) ? 2'd0 : ecnt_q + 2'd1;
      end
    end
  end

  // Hold the first two corners; on the third form edges and UV deltas
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      held_idx_q[ccnt_q] <= vertex_index_i[HeldW-1:0];
      if (ccnt_q != 2'd2) begin
        held_pos_q[ccnt_q[0]]    <= pos_in;
        held_tex_q[ccnt_q[0]][0] <= tex_u_i;
        held_tex_q[ccnt_q[0]][1] <= tex_v_i;
      end else begin
        for (int k = 0; k < AxisNum; k++) begin
          e1_q[k] <= sub_ext(held_pos_q[1][k], held_pos_q[0][k]);
          e2_q[k] <= sub_ext(pos_in[k], held_pos_q[0][k]);
        end
        du1_q <= sub_ext(held_tex_q[1][0], held_tex_q[0][0]);
        dv1_q <= sub_ext(held_tex_q[1][1], held_tex_q[0][1]);
        du2_q <= sub_ext(tex_u_i, held_tex_q[0][0]);
        dv2_q <= sub_ext(tex_v_i, held_tex_q[0][1]);
      end
    end
  end

  ttg_mac u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (mac_ctl),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .acc_o  (acc)
  );

  // Magnitudes for the divider
  always_comb begin
    dm = acc[AccDet][AccW-1] ? mag_t'(-acc[AccDet]) : mag_t'(acc[AccDet]);
    for (int k = 0; k < AxisNum; k++) begin
      nm[k] = acc[k+1][AccW-1] ? mag_t'(-acc[k+1]) : mag_t'(acc[k+1]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (div_start) begin
      degen_q <= (acc[AccDet] == '0);
      for (int k = 0; k < AxisNum; k++) begin
        sign_q[k] <= acc[k+1][AccW-1] ^ acc[AccDet][AccW-1];
      end
    end
  end

  ttg_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .dm_i    (dm),
    .nm_i    (nm),
    .q_o     (quot),
    .ovf_o   (ovf),
    .done_o  (div_done)
  );

  // Apply sign and saturate; zero on a degenerate triangle
  always_comb begin
    for (int k = 0; k < AxisNum; k++) begin
      if (degen_q) begin
        tan_d[k] = '0;
      end else if (sign_q[k]) begin
        tan_d[k] = (ovf[k] || quot[k][QuotW-1]) ? TanMin : '0 - quot[k];
      end else begin
        tan_d[k] = (ovf[k] || quot[k][QuotW-1]) ? TanMax : quot[k];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_FIN) begin
      tan_q <= tan_d;
    end
  end

  assign out_vertex_index_o = OutIdxW'(held_idx_q[ecnt_q]);
  assign tangent_x_o        = tan_q[0];
  assign tangent_y_o        = tan_q[1];
  assign tangent_z_o        = tan_q[2];
  assign degenerate_o       = degen_q;
  assign last_o             = (ecnt_q == 2'd2);

endmodule

`default_nettype wire

// File: src/ttg_checker.sv
`default_nettype none
`include "assert_macros.svh"

module ttg_checker import ttg_pkg::*; (
  input logic                    clk_i,
  input logic                    rst_ni,
  input logic                    in_ready_o,
  input logic                    out_valid_o,
  input logic                    out_ready_i,
  input logic [OutIdxW-1:0]      out_vertex_index_o,
  input logic signed [QuotW-1:0] tangent_x_o,
  input logic signed [QuotW-1:0] tangent_y_o,
  input logic signed [QuotW-1:0] tangent_z_o,
  input logic                    degenerate_o,
  input logic                    last_o
);

  `ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i,
    out_valid_o && $stable(tangent_x_o) && $stable(out_vertex_index_o) && $stable(last_o))

  `ASSERT_IMPLY(a_degen_zero, out_valid_o && degenerate_o, tangent_x_o == '0 && tangent_y_o == '0 && tangent_z_o == '0)

  `ASSERT_IMPLY(a_no_overlap, in_ready_o, !out_valid_o)

  `ASSERT_NEXT(a_burst, out_valid_o && out_ready_i && !last_o, out_valid_o && !in_ready_o)

endmodule

bind triangle_tangent_generator_top ttg_checker u_checker (.*);

`default_nettype wire
